// ----- rtl/core/ceplc_pkg.sv -----
// Shared types, constants and rounding helpers of the circle eraser polyline clipper.
`default_nettype none
package ceplc_pkg;

    localparam int CW         = 16;
    localparam int TBITS      = 24;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = TBITS;
    localparam logic [24:0] TONE       = 25'(1) << TBITS;
    localparam logic [14:0] RADIUS_RST = 15'd256;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_LINE = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic {
        SD_SQRT = 1'b0,
        SD_DIV  = 1'b1
    } t_sd_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_AXX, ST_AYY, ST_HX, ST_HY, ST_CX, ST_CY, ST_R2, ST_AR2,
        ST_CC, ST_DISC, ST_SQRT, ST_NUM0, ST_DIV0, ST_NUM1, ST_DIV1,
        ST_PIECE, ST_MY, ST_MXX, ST_MYY, ST_MCMP, ST_FY, ST_GX, ST_GY,
        ST_GEND, ST_MOVE, ST_LINE, ST_FIN, ST_FLUSH
    } t_state;

    // round to nearest, ties up, of v / 2^17
    function automatic logic signed [26:0] rnd_mid(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd65536;
        return $signed(t[43:17]);
    endfunction

    // round to nearest, ties up, of v / 2^24
    function automatic logic signed [16:0] rnd_pt(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd8388608;
        return $signed(t[40:24]);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ceplc_pt_if.sv -----
// Path point channel.
`default_nettype none
interface ceplc_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               new_subpath;
    logic               path_end;

    modport source (output valid, point_x, point_y, new_subpath, path_end, input ready);
    modport sink   (input valid, point_x, point_y, new_subpath, path_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ceplc_res_if.sv -----
// Result command channel.
`default_nettype none
interface ceplc_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               erased;
    logic               last_of_run;

    modport source (output valid, kind, out_x, out_y, erased, last_of_run, input ready);
    modport sink   (input valid, kind, out_x, out_y, erased, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/circle_eraser_polyline_clip_unit.sv -----
// Circle eraser polyline clipper: top level with sequencer and datapath.
// One point at a time, ready only in idle. A subpath start goes straight to the finish step;
// a segment runs its products on the shared multiplier, then, when the line meets the circle,
// a square root and up to two divides on the bit-serial root/divide unit, then each kept or
// erased piece, then the finish step. Output stalls hold the steps that emit results.
// Synchronous active-low reset: config returns to center 0, radius 256; path state clears.
`default_nettype none
module circle_eraser_polyline_clip_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    ceplc_pt_if.sink         i_pt,
    ceplc_res_if.source      o_res
);
    ceplc_pkg::t_state r_state, n_state;

    logic signed [15:0] r_cx, n_cx, r_cy, n_cy;
    logic [14:0]        r_rad, n_rad;
    logic signed [15:0] r_px, n_px, r_py, n_py, r_ex, n_ex, r_ey, n_ey;
    logic               r_have, n_have, r_open, n_open, r_erased, n_erased;
    logic signed [15:0] r_qx, n_qx, r_qy, n_qy;
    logic               r_last, n_last;
    logic signed [16:0] r_dx, n_dx, r_dy, n_dy, r_ox, n_ox, r_oy, n_oy;
    logic [33:0]        r_a, n_a;
    logic signed [35:0] r_h, n_h, r_cr, n_cr;
    logic [29:0]        r_r2, n_r2;
    logic [63:0]        r_ar2, n_ar2;
    logic [31:0]        r_s, n_s;
    logic [23:0]        r_t0, n_t0, r_t1, n_t1;
    logic               r_v0, n_v0, r_v1, n_v1;
    logic [24:0]        r_f, n_f, r_g, n_g;
    logic               r_fin, n_fin;
    logic [25:0]        r_msum, n_msum;
    logic signed [26:0] r_mx, n_mx, r_my, n_my;
    logic [53:0]        r_m2, n_m2;
    logic signed [15:0] r_fx, n_fx, r_fy, n_fy, r_gx, n_gx, r_gy, n_gy;
    logic               r_pv, n_pv;
    ceplc_pkg::t_kind   r_p_kind, n_p_kind;
    logic signed [15:0] r_p_x, n_p_x, r_p_y, n_p_y;
    logic               r_p_er, n_p_er;
    logic               r_ov, n_ov;
    ceplc_pkg::t_kind   r_o_kind, n_o_kind;
    logic signed [15:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic               r_o_er, n_o_er, r_o_last, n_o_last;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] w_prod;
    logic               sd_start, sd_done;
    ceplc_pkg::t_sd_op  sd_op;
    logic [63:0]        sd_num;
    logic [31:0]        sd_res;

    logic               push_req, flush_req, do_push, do_flush;
    ceplc_pkg::t_kind   push_kind;
    logic signed [15:0] push_x, push_y;
    logic               push_er;

    logic               w_out_free, w_can_push;
    logic [35:0]        w_acr;
    logic signed [37:0] w_hx, w_sx, w_ax, w_n0, w_n1;
    logic [24:0]        w_gsel;
    logic               w_gfin;
    logic [25:0]        w_msum;
    logic signed [26:0] w_oxs, w_oys;
    logic [54:0]        w_msq, w_lim;
    logic signed [16:0] w_rp, w_fxs, w_fys;

    ceplc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_prod)
    );

    ceplc_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sd_start),
        .i_op    (sd_op),
        .i_num   (sd_num),
        .i_den   (r_a),
        .o_done  (sd_done),
        .o_res   (sd_res)
    );

    assign w_out_free = !r_ov || o_res.ready;
    assign w_can_push = !r_pv || w_out_free;
    assign w_acr      = r_cr[35] ? 36'(-r_cr) : 36'(r_cr);
    assign w_hx       = 38'(r_h);
    assign w_sx       = $signed({6'd0, r_s});
    assign w_ax       = $signed({4'd0, r_a});
    assign w_n0       = -w_hx - w_sx;
    assign w_n1       = -w_hx + w_sx;
    assign w_gsel     = r_v0 ? {1'b0, r_t0} : (r_v1 ? {1'b0, r_t1} : ceplc_pkg::TONE);
    assign w_gfin     = !r_v0 && !r_v1;
    assign w_msum     = 26'(r_f) + 26'(w_gsel);
    assign w_oxs      = {{2{r_ox[16]}}, r_ox, 8'd0};
    assign w_oys      = {{2{r_oy[16]}}, r_oy, 8'd0};
    assign w_msq      = 55'(r_m2) + 55'(w_prod[53:0]);
    assign w_lim      = 55'({r_r2, 16'd0});
    assign w_rp       = ceplc_pkg::rnd_pt(w_prod);
    assign w_fxs      = 17'(r_px) + w_rp;
    assign w_fys      = 17'(r_py) + w_rp;

    assign i_pt.ready        = (r_state == ceplc_pkg::ST_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.kind        = r_o_kind;
    assign o_res.out_x       = r_o_x;
    assign o_res.out_y       = r_o_y;
    assign o_res.erased      = r_o_er;
    assign o_res.last_of_run = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ceplc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cx = r_cx;   n_cy = r_cy;   n_rad = r_rad;
        n_px = r_px;   n_py = r_py;   n_ex = r_ex;   n_ey = r_ey;
        n_have = r_have; n_open = r_open; n_erased = r_erased;
        n_qx = r_qx;   n_qy = r_qy;   n_last = r_last;
        n_dx = r_dx;   n_dy = r_dy;   n_ox = r_ox;   n_oy = r_oy;
        n_a = r_a;     n_h = r_h;     n_cr = r_cr;   n_r2 = r_r2;
        n_ar2 = r_ar2; n_s = r_s;
        n_t0 = r_t0;   n_t1 = r_t1;   n_v0 = r_v0;   n_v1 = r_v1;
        n_f = r_f;     n_g = r_g;     n_fin = r_fin; n_msum = r_msum;
        n_mx = r_mx;   n_my = r_my;   n_m2 = r_m2;
        n_fx = r_fx;   n_fy = r_fy;   n_gx = r_gx;   n_gy = r_gy;
        n_pv = r_pv;   n_p_kind = r_p_kind; n_p_x = r_p_x; n_p_y = r_p_y;
        n_p_er = r_p_er;
        n_ov = r_ov;   n_o_kind = r_o_kind; n_o_x = r_o_x; n_o_y = r_o_y;
        n_o_er = r_o_er; n_o_last = r_o_last;
        mul_a = '0;
        mul_b = '0;
        sd_start = 1'b0;
        sd_op = ceplc_pkg::SD_SQRT;
        sd_num = '0;
        push_req = 1'b0;
        push_kind = ceplc_pkg::KIND_LINE;
        push_x = '0;
        push_y = '0;
        push_er = 1'b0;
        flush_req = 1'b0;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ceplc_pkg::CFG_CENTER_X: n_cx = $signed(i_cfg_data);
                ceplc_pkg::CFG_CENTER_Y: n_cy = $signed(i_cfg_data);
                ceplc_pkg::CFG_RADIUS:   n_rad = i_cfg_data[14:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ceplc_pkg::ST_IDLE: begin
                if (i_pt.valid) begin
                    n_qx = i_pt.point_x;
                    n_qy = i_pt.point_y;
                    n_last = i_pt.path_end;
                    n_dx = 17'(i_pt.point_x) - 17'(r_px);
                    n_dy = 17'(i_pt.point_y) - 17'(r_py);
                    n_ox = 17'(r_px) - 17'(r_cx);
                    n_oy = 17'(r_py) - 17'(r_cy);
                    n_v0 = 1'b0;
                    n_v1 = 1'b0;
                    n_f = '0;
                    if (i_pt.new_subpath || !r_have) begin
                        n_open = 1'b0;
                        n_state = ceplc_pkg::ST_FIN;
                    end else begin
                        n_state = ceplc_pkg::ST_AXX;
                    end
                end
            end
            ceplc_pkg::ST_AXX: begin
                mul_a = 35'(r_dx); mul_b = 33'(r_dx);
                n_state = ceplc_pkg::ST_AYY;
            end
            ceplc_pkg::ST_AYY: begin
                mul_a = 35'(r_dy); mul_b = 33'(r_dy);
                n_a = w_prod[33:0];
                n_state = ceplc_pkg::ST_HX;
            end
            ceplc_pkg::ST_HX: begin
                mul_a = 35'(r_ox); mul_b = 33'(r_dx);
                n_a = r_a + w_prod[33:0];
                n_state = ceplc_pkg::ST_HY;
            end
            ceplc_pkg::ST_HY: begin
                mul_a = 35'(r_oy); mul_b = 33'(r_dy);
                n_h = 36'(w_prod);
                n_state = ceplc_pkg::ST_CX;
            end
            ceplc_pkg::ST_CX: begin
                mul_a = 35'(r_ox); mul_b = 33'(r_dy);
                n_h = r_h + 36'(w_prod);
                n_state = ceplc_pkg::ST_CY;
            end
            ceplc_pkg::ST_CY: begin
                mul_a = 35'(r_oy); mul_b = 33'(r_dx);
                n_cr = 36'(w_prod);
                n_state = ceplc_pkg::ST_R2;
            end
            ceplc_pkg::ST_R2: begin
                mul_a = 35'(r_rad); mul_b = 33'(r_rad);
                n_cr = r_cr - 36'(w_prod);
                n_state = ceplc_pkg::ST_AR2;
            end
            ceplc_pkg::ST_AR2: begin
                mul_a = 35'(r_a); mul_b = 33'(w_prod[29:0]);
                n_r2 = w_prod[29:0];
                n_state = ceplc_pkg::ST_CC;
            end
            ceplc_pkg::ST_CC: begin
                mul_a = 35'(w_acr[31:0]); mul_b = 33'(w_acr[31:0]);
                n_ar2 = w_prod[63:0];
                n_state = ceplc_pkg::ST_DISC;
            end
            ceplc_pkg::ST_DISC: begin
                if (r_a != '0 && w_acr[35:32] == '0 && r_ar2 > w_prod[63:0]) begin
                    sd_start = 1'b1;
                    sd_op = ceplc_pkg::SD_SQRT;
                    sd_num = r_ar2 - w_prod[63:0];
                    n_state = ceplc_pkg::ST_SQRT;
                end else begin
                    n_state = ceplc_pkg::ST_PIECE;
                end
            end
            ceplc_pkg::ST_SQRT: begin
                if (sd_done) begin
                    n_s = sd_res;
                    n_state = ceplc_pkg::ST_NUM0;
                end
            end
            ceplc_pkg::ST_NUM0: begin
                if (w_n0 > 38'sd0 && w_n0 < w_ax) begin
                    sd_start = 1'b1;
                    sd_op = ceplc_pkg::SD_DIV;
                    sd_num = 64'(w_n0[33:0]);
                    n_state = ceplc_pkg::ST_DIV0;
                end else begin
                    n_state = ceplc_pkg::ST_NUM1;
                end
            end
            ceplc_pkg::ST_DIV0: begin
                if (sd_done) begin
                    n_t0 = sd_res[23:0];
                    n_v0 = 1'b1;
                    n_state = ceplc_pkg::ST_NUM1;
                end
            end
            ceplc_pkg::ST_NUM1: begin
                if (w_n1 > 38'sd0 && w_n1 < w_ax) begin
                    sd_start = 1'b1;
                    sd_op = ceplc_pkg::SD_DIV;
                    sd_num = 64'(w_n1[33:0]);
                    n_state = ceplc_pkg::ST_DIV1;
                end else begin
                    n_state = ceplc_pkg::ST_PIECE;
                end
            end
            ceplc_pkg::ST_DIV1: begin
                if (sd_done) begin
                    n_t1 = sd_res[23:0];
                    n_v1 = 1'b1;
                    n_state = ceplc_pkg::ST_PIECE;
                end
            end
            ceplc_pkg::ST_PIECE: begin
                if (r_v0) begin
                    n_v0 = 1'b0;
                end else if (r_v1) begin
                    n_v1 = 1'b0;
                end
                if (w_gsel <= r_f) begin
                    n_f = w_gsel;
                    n_state = w_gfin ? ceplc_pkg::ST_FIN : ceplc_pkg::ST_PIECE;
                end else begin
                    n_g = w_gsel;
                    n_fin = w_gfin;
                    n_msum = w_msum;
                    mul_a = 35'(w_msum); mul_b = 33'(r_dx);
                    n_state = ceplc_pkg::ST_MY;
                end
            end
            ceplc_pkg::ST_MY: begin
                mul_a = 35'(r_msum); mul_b = 33'(r_dy);
                n_mx = w_oxs + ceplc_pkg::rnd_mid(w_prod);
                n_state = ceplc_pkg::ST_MXX;
            end
            ceplc_pkg::ST_MXX: begin
                mul_a = 35'(r_mx); mul_b = 33'(r_mx);
                n_my = w_oys + ceplc_pkg::rnd_mid(w_prod);
                n_state = ceplc_pkg::ST_MYY;
            end
            ceplc_pkg::ST_MYY: begin
                mul_a = 35'(r_my); mul_b = 33'(r_my);
                n_m2 = w_prod[53:0];
                n_state = ceplc_pkg::ST_MCMP;
            end
            ceplc_pkg::ST_MCMP: begin
                if (w_msq < w_lim) begin
                    n_erased = 1'b1;
                    n_open = 1'b0;
                    n_f = r_g;
                    n_state = r_fin ? ceplc_pkg::ST_FIN : ceplc_pkg::ST_PIECE;
                end else begin
                    mul_a = 35'(r_f); mul_b = 33'(r_dx);
                    n_state = ceplc_pkg::ST_FY;
                end
            end
            ceplc_pkg::ST_FY: begin
                mul_a = 35'(r_f); mul_b = 33'(r_dy);
                n_fx = w_fxs[15:0];
                n_state = ceplc_pkg::ST_GX;
            end
            ceplc_pkg::ST_GX: begin
                mul_a = 35'(r_g); mul_b = 33'(r_dx);
                n_fy = w_fys[15:0];
                n_state = ceplc_pkg::ST_GY;
            end
            ceplc_pkg::ST_GY: begin
                mul_a = 35'(r_g); mul_b = 33'(r_dy);
                n_gx = w_fxs[15:0];
                n_state = ceplc_pkg::ST_GEND;
            end
            ceplc_pkg::ST_GEND: begin
                n_gy = w_fys[15:0];
                n_state = ceplc_pkg::ST_MOVE;
            end
            ceplc_pkg::ST_MOVE: begin
                if (r_open && r_ex == r_fx && r_ey == r_fy) begin
                    n_state = ceplc_pkg::ST_LINE;
                end else begin
                    push_req = 1'b1;
                    push_kind = ceplc_pkg::KIND_MOVE;
                    push_x = r_fx;
                    push_y = r_fy;
                    if (w_can_push) begin
                        n_open = 1'b1;
                        n_state = ceplc_pkg::ST_LINE;
                    end
                end
            end
            ceplc_pkg::ST_LINE: begin
                push_req = 1'b1;
                push_kind = ceplc_pkg::KIND_LINE;
                push_x = r_gx;
                push_y = r_gy;
                if (w_can_push) begin
                    n_ex = r_gx;
                    n_ey = r_gy;
                    n_f = r_g;
                    n_state = r_fin ? ceplc_pkg::ST_FIN : ceplc_pkg::ST_PIECE;
                end
            end
            ceplc_pkg::ST_FIN: begin
                if (r_last) begin
                    push_req = 1'b1;
                    push_kind = ceplc_pkg::KIND_DONE;
                    push_er = r_erased;
                    if (w_can_push) begin
                        n_px = '0;
                        n_py = '0;
                        n_ex = '0;
                        n_ey = '0;
                        n_have = 1'b0;
                        n_open = 1'b0;
                        n_erased = 1'b0;
                        n_state = ceplc_pkg::ST_FLUSH;
                    end
                end else begin
                    n_px = r_qx;
                    n_py = r_qy;
                    n_have = 1'b1;
                    n_state = ceplc_pkg::ST_FLUSH;
                end
            end
            ceplc_pkg::ST_FLUSH: begin
                flush_req = 1'b1;
                if (!r_pv || w_out_free) begin
                    n_state = ceplc_pkg::ST_IDLE;
                end
            end
            default: n_state = ceplc_pkg::ST_IDLE;
        endcase

        // one result is held back so the last of a transaction can be marked
        do_push  = push_req && w_can_push;
        do_flush = flush_req && r_pv && w_out_free;
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end
        if ((do_push && r_pv) || do_flush) begin
            n_ov = 1'b1;
            n_o_kind = r_p_kind;
            n_o_x = r_p_x;
            n_o_y = r_p_y;
            n_o_er = r_p_er;
            n_o_last = do_flush;
        end
        if (do_push) begin
            n_pv = 1'b1;
            n_p_kind = push_kind;
            n_p_x = push_x;
            n_p_y = push_y;
            n_p_er = push_er;
        end else if (do_flush) begin
            n_pv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_rad <= ceplc_pkg::RADIUS_RST;
            r_px <= '0;
            r_py <= '0;
            r_ex <= '0;
            r_ey <= '0;
            r_have <= 1'b0;
            r_open <= 1'b0;
            r_erased <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_rad <= n_rad;
            r_px <= n_px;
            r_py <= n_py;
            r_ex <= n_ex;
            r_ey <= n_ey;
            r_have <= n_have;
            r_open <= n_open;
            r_erased <= n_erased;
            r_pv <= n_pv;
            r_ov <= n_ov;
        end
        r_qx <= n_qx;     r_qy <= n_qy;     r_last <= n_last;
        r_dx <= n_dx;     r_dy <= n_dy;     r_ox <= n_ox;     r_oy <= n_oy;
        r_a <= n_a;       r_h <= n_h;       r_cr <= n_cr;     r_r2 <= n_r2;
        r_ar2 <= n_ar2;   r_s <= n_s;
        r_t0 <= n_t0;     r_t1 <= n_t1;     r_v0 <= n_v0;     r_v1 <= n_v1;
        r_f <= n_f;       r_g <= n_g;       r_fin <= n_fin;   r_msum <= n_msum;
        r_mx <= n_mx;     r_my <= n_my;     r_m2 <= n_m2;
        r_fx <= n_fx;     r_fy <= n_fy;     r_gx <= n_gx;     r_gy <= n_gy;
        r_p_kind <= n_p_kind; r_p_x <= n_p_x; r_p_y <= n_p_y; r_p_er <= n_p_er;
        r_o_kind <= n_o_kind; r_o_x <= n_o_x; r_o_y <= n_o_y;
        r_o_er <= n_o_er;     r_o_last <= n_o_last;
    end
endmodule
`default_nettype wire

// ----- rtl/core/ceplc_mul.sv -----
// Shared signed multiplier with registered product.
`default_nettype none
module ceplc_mul (
    input  wire logic               i_clk,
    input  wire logic signed [34:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [67:0]      o_p
);
    logic signed [67:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 68'(i_a) * 68'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- rtl/core/ceplc_sqdiv.sv -----
// Iterative shift-subtract unit: integer square root or fraction divide.
`default_nettype none
module ceplc_sqdiv (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire ceplc_pkg::t_sd_op    i_op,
    input  wire logic [63:0]          i_num,
    input  wire logic [33:0]          i_den,
    output logic                      o_done,
    output logic [31:0]               o_res
);
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    ceplc_pkg::t_sd_op    r_op, n_op;
    logic [5:0]           r_cnt, n_cnt;
    logic [63:0]          r_v, n_v;
    logic [63:0]          r_res, n_res;
    logic [63:0]          r_bit, n_bit;
    logic [33:0]          r_den, n_den;

    logic [64:0] w_trial;
    logic [65:0] w_lhs, w_rhs, w_diff;
    logic        w_ge;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_lhs   = (r_op == ceplc_pkg::SD_SQRT) ? {2'b0, r_v} : {1'b0, r_v, 1'b0};
    assign w_rhs   = (r_op == ceplc_pkg::SD_SQRT) ? {1'b0, w_trial} : {32'd0, r_den};
    assign w_diff  = w_lhs - w_rhs;
    assign w_ge    = !w_diff[65];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_op   = i_op;
            n_v    = i_num;
            n_res  = '0;
            n_bit  = 64'(1) << 62;
            n_den  = i_den;
            n_cnt  = (i_op == ceplc_pkg::SD_SQRT) ? 6'(ceplc_pkg::SQRT_STEPS)
                                                  : 6'(ceplc_pkg::DIV_STEPS);
        end else if (r_busy) begin
            if (r_op == ceplc_pkg::SD_SQRT) begin
                if (w_ge) begin
                    n_v   = w_diff[63:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
            end else begin
                n_v   = w_ge ? w_diff[63:0] : w_lhs[63:0];
                n_res = {r_res[62:0], w_ge};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ceplc_pkg::SD_SQRT;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_res  = r_res[31:0];
endmodule
`default_nettype wire

// ----- rtl/core/ceplc_chk.sv -----
// Port-level checker for the clipper, bound to the top level.
`default_nettype none
module ceplc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_out_kind,
    input wire logic [15:0] i_out_x,
    input wire logic [15:0] i_out_y,
    input wire logic        i_out_erased,
    input wire logic        i_out_last
);
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_last))
        else $error("stalled result changed");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == ceplc_pkg::KIND_DONE
            |-> i_out_x == '0 && i_out_y == '0 && i_out_last)
        else $error("done result malformed");

    a_erased_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != ceplc_pkg::KIND_DONE |-> !i_out_erased)
        else $error("erased flag on a path command");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a transaction");
endmodule

bind circle_eraser_polyline_clip_unit ceplc_chk u_ceplc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pt.valid),
    .i_in_ready   (i_pt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_kind   (o_res.kind),
    .i_out_x      (o_res.out_x),
    .i_out_y      (o_res.out_y),
    .i_out_erased (o_res.erased),
    .i_out_last   (o_res.last_of_run)
);
`default_nettype wire

// ----- tb/ceplc_checker.sv -----
// Checker: watches point and result channels, predicts clipped commands and compares.
`timescale 1ns / 100ps
module ceplc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    ceplc_pt_if              pt,
    ceplc_res_if             res,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic        erased;
        logic        last;
    } t_cmd;

    t_cmd cmd_q[$];

    longint cx, cy, rad;
    longint prv_x, prv_y, lst_x, lst_y;
    bit     has_prev, frag_open, any_erased;

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void push_cmd(logic [1:0] k, longint x, longint y, bit e);
        t_cmd c;
        c.kind = k;
        c.x = x[15:0];
        c.y = y[15:0];
        c.erased = e;
        c.last = 1'b0;
        cmd_q.push_back(c);
    endfunction

    function automatic void clip_seg(longint px, longint py, longint qx, longint qy);
        longint dx, dy, ox, oy, a, r2, h, cr, acr, ar2, s, f, g, mx, my;
        longint fx, fy, gx, gy;
        longint nums[2];
        longint cuts[4];
        int nc;
        dx = qx - px;
        dy = qy - py;
        ox = px - cx;
        oy = py - cy;
        a = dx * dx + dy * dy;
        r2 = rad * rad;
        nc = 1;
        cuts[0] = 0;
        if (a > 0) begin
            h = ox * dx + oy * dy;
            cr = ox * dy - oy * dx;
            acr = cr < 0 ? -cr : cr;
            ar2 = a * r2;
            if (acr < (longint'(1) << 32) &&
                    longint'(unsigned'(ar2)) > 0 &&
                    $unsigned(ar2) > $unsigned(acr * acr)) begin
                s = int_sqrt(ar2 - acr * acr);
                nums[0] = -h - s;
                nums[1] = -h + s;
                for (int k = 0; k < 2; k++)
                    if (nums[k] > 0 && nums[k] < a) begin
                        cuts[nc] = (nums[k] << ceplc_pkg::TBITS) / a;
                        nc++;
                    end
            end
        end
        cuts[nc] = longint'(1) << ceplc_pkg::TBITS;
        nc++;
        for (int k = 1; k < nc; k++) begin
            f = cuts[k - 1];
            g = cuts[k];
            if (g <= f) continue;
            mx = ox * 256 + rnd_shift(dx * (f + g), ceplc_pkg::TBITS + 1 - 8);
            my = oy * 256 + rnd_shift(dy * (f + g), ceplc_pkg::TBITS + 1 - 8);
            if (mx * mx + my * my < (r2 << 16)) begin
                any_erased = 1;
                frag_open = 0;
                continue;
            end
            fx = px + rnd_shift(dx * f, ceplc_pkg::TBITS);
            fy = py + rnd_shift(dy * f, ceplc_pkg::TBITS);
            gx = px + rnd_shift(dx * g, ceplc_pkg::TBITS);
            gy = py + rnd_shift(dy * g, ceplc_pkg::TBITS);
            if (!frag_open || lst_x != fx || lst_y != fy) begin
                push_cmd(ceplc_pkg::KIND_MOVE, fx, fy, 0);
                frag_open = 1;
            end
            push_cmd(ceplc_pkg::KIND_LINE, gx, gy, 0);
            lst_x = gx;
            lst_y = gy;
        end
    endfunction

    function automatic void predict_point(logic signed [15:0] x, logic signed [15:0] y,
                                          bit start, bit fin);
        int n0;
        t_cmd c;
        n0 = cmd_q.size();
        if (start || !has_prev) frag_open = 0;
        else clip_seg(prv_x, prv_y, x, y);
        prv_x = x;
        prv_y = y;
        has_prev = 1;
        if (fin) begin
            push_cmd(ceplc_pkg::KIND_DONE, 0, 0, any_erased);
            prv_x = 0; prv_y = 0; lst_x = 0; lst_y = 0;
            has_prev = 0; frag_open = 0; any_erased = 0;
        end
        if (cmd_q.size() > n0) begin
            c = cmd_q[$];
            c.last = 1'b1;
            cmd_q[cmd_q.size() - 1] = c;
        end
    endfunction

    assign o_pending = cmd_q.size();

    always @(posedge i_clk) begin
        t_cmd e, act;
        if (!i_rst_n) begin
            cx = 0; cy = 0; rad = 256;
            prv_x = 0; prv_y = 0; lst_x = 0; lst_y = 0;
            has_prev = 0; frag_open = 0; any_erased = 0;
            cmd_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ceplc_pkg::CFG_CENTER_X: cx = longint'($signed(i_cfg_data));
                    ceplc_pkg::CFG_CENTER_Y: cy = longint'($signed(i_cfg_data));
                    ceplc_pkg::CFG_RADIUS:   rad = longint'(i_cfg_data[14:0]);
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                act = {res.kind, res.out_x, res.out_y, res.erased, res.last_of_run};
                if (cmd_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", act);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = cmd_q.pop_front();
                    if (e != act) begin
                        if (o_fail_count < 10)
                            $display({"mismatch exp k%0d x%0d y%0d e%0b l%0b",
                                      " act k%0d x%0d y%0d e%0b l%0b"},
                                e.kind, $signed(e.x), $signed(e.y), e.erased, e.last,
                                act.kind, $signed(act.x), $signed(act.y), act.erased,
                                act.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (pt.valid && pt.ready)
                predict_point(pt.point_x, pt.point_y, pt.new_subpath, pt.path_end);
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, point stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = ceplc_pkg::CFG_CENTER_X;
    logic [15:0] cfg_data = 0;
    int          fail_count, pending;
    int          idle_cnt = 0;
    bit          no_idle = 0;
    bit          hold_res = 0;

    ceplc_pt_if  pt_if();
    ceplc_res_if res_if();

    circle_eraser_polyline_clip_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .i_pt(pt_if), .o_res(res_if)
    );

    ceplc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .pt(pt_if), .res(res_if),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        pt_if.valid = 0;
        pt_if.point_x = 0;
        pt_if.point_y = 0;
        pt_if.new_subpath = 0;
        pt_if.path_end = 0;
        res_if.ready = 0;
    end

    always @(posedge i_clk) begin
        if (hold_res) res_if.ready <= 0;
        else if (no_idle) res_if.ready <= 1;
        else res_if.ready <= ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain_out();
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit ns, bit pe);
        if (!no_idle)
            while ($urandom_range(99) < 26) begin
                pt_if.valid <= 0;
                @(posedge i_clk);
            end
        pt_if.valid <= 1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.new_subpath <= ns;
        pt_if.path_end <= pe;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
    endtask

    task automatic end_points();
        pt_if.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord(int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic rand_path(int span, int cxr);
        int n;
        n = $urandom_range(8, 2);
        send_point(rnd_coord(span) + 16'(cxr), rnd_coord(span), 1'($urandom_range(1)),
                   1'b0);
        for (int i = 1; i < n; i++)
            send_point(rnd_coord(span) + 16'(cxr), rnd_coord(span),
                       $urandom_range(9) == 0, i == n - 1 ? 1'b1 : $urandom_range(19) == 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset config, circle at origin radius 256
        send_point(-16'sd1000, 16'sd0, 1'b1, 1'b0);
        send_point(16'sd1000, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd1000, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd10, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd10, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd1000, 16'sd256, 1'b0, 1'b0);
        send_point(-16'sd1000, 16'sd256, 1'b0, 1'b0);
        send_point(-16'sd1000, 16'sd900, 1'b1, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 1'b0, 1'b0);
        send_point(-16'sh8000, 16'sh7fff, 1'b0, 1'b1);
        send_point(16'sd5, 16'sd5, 1'b0, 1'b1);
        end_points();
        drain_out();

        write_reg(ceplc_pkg::CFG_RADIUS, 16'h7fff);
        write_reg(ceplc_pkg::CFG_CENTER_X, 16'h7fff);
        write_reg(ceplc_pkg::CFG_CENTER_Y, 16'h8000);
        send_point(-16'sh8000, 16'sh7fff, 1'b1, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        end_points();
        drain_out();

        write_reg(ceplc_pkg::CFG_RADIUS, 16'h0000);
        write_reg(ceplc_pkg::CFG_CENTER_X, 16'h0000);
        write_reg(ceplc_pkg::CFG_CENTER_Y, 16'h0000);
        send_point(-16'sd100, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        end_points();
        drain_out();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(ceplc_pkg::CFG_CENTER_X, 16'($urandom_range(4000)) - 16'd2000);
            write_reg(ceplc_pkg::CFG_CENTER_Y, 16'($urandom_range(4000)) - 16'd2000);
            write_reg(ceplc_pkg::CFG_RADIUS,
                      ph == 3 ? 16'h7fff : 16'($urandom_range(2000, 50)));
            no_idle = (ph == 1);
            for (int p = 0; p < 20; p++) begin
                if (ph == 2 && p == 3) begin
                    fork
                        begin
                            hold_res = 1;
                            repeat (600) @(posedge i_clk);
                            hold_res = 0;
                        end
                    join_none
                end
                if ($urandom_range(9) == 0) begin
                    send_point(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                end else begin
                    rand_path(ph == 3 ? 32767 : 3000, 0);
                end
            end
            end_points();
            drain_out();
        end
        no_idle = 0;

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- circle_eraser_polyline_clip_unit.f -----
rtl/core/ceplc_pkg.sv
rtl/core/ceplc_pt_if.sv
rtl/core/ceplc_res_if.sv
rtl/core/ceplc_mul.sv
rtl/core/ceplc_sqdiv.sv
rtl/core/circle_eraser_polyline_clip_unit.sv
rtl/core/ceplc_chk.sv
tb/ceplc_checker.sv
tb/tb_top.sv
